// File: sv/tps_pkg.sv
`timescale 1ns / 1ps

package tps_pkg;

  // Number of task slots, one chain cell per slot.
  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int CMD_W     = 2;
  localparam int ID_W      = 32;
  localparam int STATUS_W  = 3;

  localparam int S_FIELDS_W = CMD_W + ID_W + 1;
  localparam int M_FIELDS_W = STATUS_W + ID_W + 1;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SPAWN    = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_REPORT   = 2'd2,
    CMD_WAKE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_FREE    = 2'd0,
    KIND_READY   = 2'd1,
    KIND_RUNNING = 2'd2,
    KIND_PENDING = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NONE_READY   = 3'd1,
    ST_ALL_DONE     = 3'd2,
    ST_FULL         = 3'd3,
    ST_NOT_PENDING  = 3'd4,
    ST_NONE_RUNNING = 3'd5,
    ST_BUSY         = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    OP_FIND_FREE = 2'd0,
    OP_FIND_PEND = 2'd1,
    OP_SET_KIND  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_POP   = 2'd1,
    S_CHAIN = 2'd2,
    S_RESP  = 2'd3
  } state_e;

  // Token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic              vld;
    op_e               op;
    logic [ID_W-1:0]   key;
    logic [SLOT_W-1:0] slot;
    kind_e             kind;
    logic              hit;
  } tok_t;

  // One ready queue entry: slot number and the id of its task.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
  } rq_entry_t;

endpackage

// File: sv/tps_cell.sv
`timescale 1ns / 1ps

module tps_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [tps_pkg::SLOT_W-1:0] idx_i,
  input  tps_pkg::tok_t             tok_i,
  output tps_pkg::tok_t             tok_o
);
  import tps_pkg::*;

  kind_e           kind_q, kind_d;
  logic [ID_W-1:0] id_q, id_d;
  tok_t            tok_q, tok_d;

  // The first matching cell claims a search token; later cells see hit set.
  always_comb begin
    kind_d = kind_q;
    id_d   = id_q;
    tok_d  = tok_i;
    if (tok_i.vld) begin
      case (tok_i.op)
        OP_FIND_FREE: begin
          if (!tok_i.hit && kind_q == KIND_FREE) begin
            kind_d     = KIND_READY;
            id_d       = tok_i.key;
            tok_d.hit  = 1'b1;
            tok_d.slot = idx_i;
          end
        end
        OP_FIND_PEND: begin
          if (!tok_i.hit && kind_q == KIND_PENDING && id_q == tok_i.key) begin
            kind_d     = KIND_READY;
            tok_d.hit  = 1'b1;
            tok_d.slot = idx_i;
          end
        end
        OP_SET_KIND: begin
          if (tok_i.slot == idx_i) begin
            kind_d    = tok_i.kind;
            tok_d.hit = 1'b1;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_FREE;
      tok_q  <= '0;
    end else begin
      kind_q <= kind_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign tok_o = tok_q;

endmodule

// File: sv/tps_ready_fifo.sv
`timescale 1ns / 1ps

module tps_ready_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  tps_pkg::rq_entry_t        push_data_i,
  input  logic                      pop_i,
  output tps_pkg::rq_entry_t        head_o,
  output logic [tps_pkg::CNT_W-1:0] count_o
);
  import tps_pkg::*;

  rq_entry_t         mem [MAX_TASKS];
  rq_entry_t         rd_q;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [SLOT_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] p);
    logic [SLOT_W-1:0] r;
    if (p == SLOT_W'(MAX_TASKS - 1)) begin
      r = '0;
    end else begin
      r = p + SLOT_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d = wrap_inc(tail_q);
    end
    if (pop_i) begin
      head_d = wrap_inc(head_q);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[head_q];
  end

  assign head_o  = rd_q;
  assign count_o = count_q;

endmodule

// File: sv/task_ready_pending_scheduler_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Signals                          Transaction
// s_axis   in         tvalid, tready, tdata[39:0]      one scheduler command
// m_axis   out        tvalid, tready, tdata[39:0]      one status result
//
// Each command takes one transaction in and gives exactly one transaction out.
// Chain commands (spawn, wake, a report of the running task and a dispatch that
// finds a ready task) pass a token through every cell, one cell per slot, before
// they load their result; a dispatch first pops the ready queue. The others load
// it without the chain. The next command is taken in the cycle after the load.
// Reset is asynchronous and active low; it frees every slot at once.
// A stalled result lets the next command run but holds back its result.

module task_ready_pending_scheduler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] cmd, [33:2] task_id, [34] poll_done, [39:35] zero
  input  logic [tps_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] status, [34:3] result_id, [35] finished, [39:36] zero
  output logic [tps_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import tps_pkg::*;

  // Unpacked view of the incoming transaction.
  cmd_e            in_cmd;
  logic [ID_W-1:0] in_task_id;
  logic            in_poll_done;
  logic            accept;

  assign in_cmd       = cmd_e'(s_axis_tdata[CMD_W-1:0]);
  assign in_task_id   = s_axis_tdata[CMD_W +: ID_W];
  assign in_poll_done = s_axis_tdata[CMD_W + ID_W];
  assign accept       = s_axis_tvalid && s_axis_tready;

  state_e state_q, state_d;

  // Running task is tracked here, so its id never has to be read back out of
  // the chain.
  logic              run_vld_q, run_vld_d;
  logic [SLOT_W-1:0] run_slot_q, run_slot_d;
  logic [ID_W-1:0]   run_id_q, run_id_d;
  logic [CNT_W-1:0]  pend_cnt_q, pend_cnt_d;
  logic [ID_W-1:0]   next_id_q, next_id_d, next_id_inc;

  // Result being assembled, and the output register that holds it.
  status_e         res_status_q, res_status_d;
  logic [ID_W-1:0] res_id_q, res_id_d;
  logic            res_fin_q, res_fin_d;
  logic            out_vld_q, out_vld_d;
  logic [M_TDATA_W-1:0] out_data_q;
  logic            out_load;

  // Ready queue.
  logic       rq_push, rq_pop;
  rq_entry_t  rq_push_data, rq_head;
  logic [CNT_W-1:0] rq_count;

  // Cell chain: chain[0] is the token launched by the sequencer, and
  // chain[MAX_TASKS] is what leaves the last cell.
  tok_t launch_tok;
  tok_t chain [MAX_TASKS+1];
  tok_t chain_end;

  assign chain[0]  = launch_tok;
  assign chain_end = chain[MAX_TASKS];

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cells
    tps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SLOT_W'(g)),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  tps_ready_fifo u_ready_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rq_push),
    .push_data_i (rq_push_data),
    .pop_i       (rq_pop),
    .head_o      (rq_head),
    .count_o     (rq_count)
  );

  // Ids count up from one and skip zero when they wrap.
  assign next_id_inc = (next_id_q == '1) ? ID_FIRST : next_id_q + ID_FIRST;

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_load      = (state_q == S_RESP) && (!out_vld_q || m_axis_tready);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_SPAWN, CMD_WAKE: state_d = S_CHAIN;
            CMD_DISPATCH: begin
              if (run_vld_q || rq_count == '0) begin
                state_d = S_RESP;
              end else begin
                state_d = S_POP;
              end
            end
            CMD_REPORT: state_d = run_vld_q ? S_CHAIN : S_RESP;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_POP:   state_d = S_CHAIN;
      S_CHAIN: begin
        if (chain_end.vld) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and control outputs.
  always_comb begin
    run_vld_d    = run_vld_q;
    run_slot_d   = run_slot_q;
    run_id_d     = run_id_q;
    pend_cnt_d   = pend_cnt_q;
    next_id_d    = next_id_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_fin_d    = res_fin_q;
    launch_tok   = '0;
    rq_push      = 1'b0;
    rq_pop       = 1'b0;
    rq_push_data = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_OK;
          res_id_d     = '0;
          res_fin_d    = 1'b0;
          case (in_cmd)
            CMD_SPAWN: begin
              launch_tok.vld = 1'b1;
              launch_tok.op  = OP_FIND_FREE;
              launch_tok.key = next_id_q;
            end
            CMD_DISPATCH: begin
              if (run_vld_q) begin
                res_status_d = ST_BUSY;
                res_id_d     = run_id_q;
              end else if (rq_count == '0) begin
                res_status_d = (pend_cnt_q != '0) ? ST_NONE_READY : ST_ALL_DONE;
              end
            end
            CMD_REPORT: begin
              if (!run_vld_q) begin
                res_status_d = ST_NONE_RUNNING;
              end else begin
                res_id_d        = run_id_q;
                res_fin_d       = in_poll_done;
                run_vld_d       = 1'b0;
                launch_tok.vld  = 1'b1;
                launch_tok.op   = OP_SET_KIND;
                launch_tok.slot = run_slot_q;
                launch_tok.kind = in_poll_done ? KIND_FREE : KIND_PENDING;
                if (!in_poll_done) begin
                  pend_cnt_d = pend_cnt_q + CNT_W'(1);
                end
              end
            end
            CMD_WAKE: begin
              launch_tok.vld = 1'b1;
              launch_tok.op  = OP_FIND_PEND;
              launch_tok.key = in_task_id;
            end
            default: begin
              launch_tok = '0;
            end
          endcase
        end
      end

      S_POP: begin
        // The registered head entry has been stable since acceptance.
        rq_pop          = 1'b1;
        run_vld_d       = 1'b1;
        run_slot_d      = rq_head.slot;
        run_id_d        = rq_head.id;
        res_status_d    = ST_OK;
        res_id_d        = rq_head.id;
        res_fin_d       = 1'b0;
        launch_tok.vld  = 1'b1;
        launch_tok.op   = OP_SET_KIND;
        launch_tok.slot = rq_head.slot;
        launch_tok.kind = KIND_RUNNING;
      end

      S_CHAIN: begin
        if (chain_end.vld) begin
          case (chain_end.op)
            OP_FIND_FREE: begin
              if (chain_end.hit) begin
                rq_push           = 1'b1;
                rq_push_data.slot = chain_end.slot;
                rq_push_data.id   = chain_end.key;
                next_id_d         = next_id_inc;
                res_status_d      = ST_OK;
                res_id_d          = chain_end.key;
              end else begin
                res_status_d = ST_FULL;
                res_id_d     = '0;
              end
            end
            OP_FIND_PEND: begin
              if (chain_end.hit) begin
                rq_push           = 1'b1;
                rq_push_data.slot = chain_end.slot;
                rq_push_data.id   = chain_end.key;
                if (pend_cnt_q != '0) begin
                  pend_cnt_d = pend_cnt_q - CNT_W'(1);
                end
                res_status_d = ST_OK;
                res_id_d     = chain_end.key;
              end else begin
                res_status_d = ST_NOT_PENDING;
                res_id_d     = '0;
              end
            end
            default: begin
              res_status_d = res_status_q;
            end
          endcase
        end
      end

      default: begin
        res_status_d = res_status_q;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      run_vld_q  <= 1'b0;
      pend_cnt_q <= '0;
      next_id_q  <= ID_FIRST;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      run_vld_q  <= run_vld_d;
      pend_cnt_q <= pend_cnt_d;
      next_id_q  <= next_id_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_slot_q   <= run_slot_d;
    run_id_q     <= run_id_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_fin_q    <= res_fin_d;
    if (out_load) begin
      out_data_q <= M_TDATA_W'({res_fin_q, res_id_q, res_status_q});
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sv/tps_checker.sv
`timescale 1ns / 1ps

module tps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tps_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import tps_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [ID_W-1:0]     rid;
  logic                fin;

  assign st  = m_axis_tdata[STATUS_W-1:0];
  assign rid = m_axis_tdata[STATUS_W +: ID_W];
  assign fin = m_axis_tdata[STATUS_W + ID_W];

  // Only one command is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while another was in flight");

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Only a successful report can retire a task.
  a_fin_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && fin |-> st == ST_OK)
    else $error("finished flag on a failed command");

  // Every success and every busy report names a real task.
  a_ok_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_OK || st == ST_BUSY) |-> rid != '0)
    else $error("successful result without a task id");

  // Failure codes never carry an id.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_NONE_READY || st == ST_ALL_DONE || st == ST_FULL ||
                      st == ST_NOT_PENDING || st == ST_NONE_RUNNING)
    |-> rid == '0)
    else $error("failure result with a task id");

endmodule

bind task_ready_pending_scheduler_top tps_checker u_tps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
